FILE: rtl/core/drc_pkg.sv
// Shared types and fixed field widths for the direct-mapped range cache.
// No dependencies; used by drc_front, drc_back and the top level.
`timescale 1ns / 1ps
`default_nettype none

package drc_pkg;

   // Field widths fixed by the transaction format
   localparam int IDX_W      = 31;
   localparam int CNT_W      = 9;
   localparam int ADDR_W     = 48;
   localparam int BYTES_W    = 15;
   localparam int SLOT_OUT_W = 8;
   localparam int TAG_W      = IDX_W + 1;   // valid bit over element index

   // Front/back queue depth
   localparam int QUEUE_DEPTH = 2;

   // Run plan of one request: first run, then an optional wrapped run at slot 0
   typedef struct packed {
      logic [IDX_W-1:0] idx1;
      logic [IDX_W-1:0] idx2;
      logic [CNT_W-1:0] len1;
      logic [CNT_W-1:0] len2;
   } run_type;

endpackage

`default_nettype wire

FILE: rtl/core/drc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module drc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/core/drc_queue.sv
// Small flop-based FIFO that decouples the request front end from the tag back end.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module drc_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire logic [WIDTH-1:0] in_data,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output logic      [WIDTH-1:0] out_data
);

   localparam int PW = $clog2(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PW:0]      fill_ff, fill_in;
   logic             push, pop;

   assign in_ready  = (fill_ff != (PW+1)'(DEPTH));
   assign out_valid = (fill_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Entry storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/drc_front.sv
// Request front end: accepts a range, finds its first slot and splits it into runs.
// Depends on drc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module drc_front #(
   parameter int CACHE_ENTRIES = 256
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               clearing,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [drc_pkg::IDX_W-1:0]          req_first_index,
   input  wire logic [drc_pkg::CNT_W-1:0]          req_element_count,
   output logic                                    q_valid,
   input  wire logic                               q_ready,
   output logic      [$clog2(CACHE_ENTRIES)-1:0]   q_slot,
   output drc_pkg::run_type                        q_run
);

   localparam int SW    = $clog2(CACHE_ENTRIES);
   localparam int IDX_W = drc_pkg::IDX_W;
   localparam int CNT_W = drc_pkg::CNT_W;
   localparam int RCP_W = IDX_W + 1;
   localparam int SCL_W = IDX_W + RCP_W;
   localparam int SHIFT = IDX_W + SW;
   localparam int CMP_W = (SW + 1 > CNT_W) ? SW + 1 : CNT_W;
   // ceil(2^SHIFT / CACHE_ENTRIES) gives the exact quotient for every 31-bit index
   localparam logic [RCP_W-1:0] RCP = RCP_W'(((64'd1 << SHIFT) + 64'(CACHE_ENTRIES - 1))
                                             / 64'(CACHE_ENTRIES));
   localparam logic [IDX_W-1:0] N_I = IDX_W'(CACHE_ENTRIES);
   localparam logic [CMP_W-1:0] N_C = CMP_W'(CACHE_ENTRIES);

   typedef enum logic [1:0] {
      FS_IDLE,
      FS_SCALE,
      FS_REMAIN,
      FS_PUSH
   } state_type;

   state_type        state_ff;
   logic [IDX_W-1:0] first_ff;
   logic [CNT_W-1:0] count_ff;
   logic [IDX_W-1:0] quot_ff, quot_in;
   logic [SW-1:0]    rem_ff, rem_in;
   logic [SCL_W-1:0] scaled;
   logic [CMP_W-1:0] count_sat, room, len1, len2;

   assign req_ready = (state_ff == FS_IDLE) && !clearing;
   assign q_valid   = (state_ff == FS_PUSH);

   // Quotient by the table size through a reciprocal multiply, then the slot
   // as index minus quotient times table size
   assign scaled  = SCL_W'(first_ff) * SCL_W'(RCP);
   assign quot_in = IDX_W'(scaled >> SHIFT);
   assign rem_in  = SW'(first_ff - quot_ff * N_I);

   // Split into a run up to the table end and a wrapped run from slot 0
   always_comb begin
      count_sat = (CMP_W'(count_ff) > N_C) ? N_C : CMP_W'(count_ff);
      room      = N_C - CMP_W'(rem_ff);
      len1      = (count_sat < room) ? count_sat : room;
      len2      = count_sat - len1;
   end

   assign q_slot     = rem_ff;
   assign q_run.idx1 = first_ff;
   assign q_run.idx2 = first_ff + IDX_W'(len1);
   assign q_run.len1 = CNT_W'(len1);
   assign q_run.len2 = CNT_W'(len2);

   // Control sequence and working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FS_IDLE;
      end else begin
         case (state_ff)
            FS_IDLE: begin
               // an empty range is taken and dropped
               if (req_valid && req_ready && (req_element_count != '0)) begin
                  first_ff <= req_first_index;
                  count_ff <= req_element_count;
                  state_ff <= FS_SCALE;
               end
            end
            FS_SCALE: begin
               quot_ff  <= quot_in;
               state_ff <= FS_REMAIN;
            end
            FS_REMAIN: begin
               rem_ff   <= rem_in;
               state_ff <= FS_PUSH;
            end
            FS_PUSH: begin
               if (q_ready) begin
                  state_ff <= FS_IDLE;
               end
            end
            default: begin
               state_ff <= FS_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/drc_back.sv
// Tag back end: compares and updates tags run by run, drives the response register,
// holds the base address and clears the tag RAM. Depends on drc_pkg and drc_ram.
`timescale 1ns / 1ps
`default_nettype none

module drc_back #(
   parameter int CACHE_ENTRIES = 256,
   parameter int ELEMENT_BYTES = 64
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_enable,
   input  wire logic [drc_pkg::ADDR_W-1:0]          csr_write_data,
   output logic                                     clearing,
   input  wire logic                                q_valid,
   output logic                                     q_ready,
   input  wire logic [$clog2(CACHE_ENTRIES)-1:0]    q_slot,
   input  wire drc_pkg::run_type                    q_run,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic      [drc_pkg::SLOT_OUT_W-1:0]      rsp_slot,
   output logic      [drc_pkg::IDX_W-1:0]           rsp_run_index,
   output logic      [drc_pkg::ADDR_W-1:0]          rsp_fetch_address,
   output logic      [drc_pkg::BYTES_W-1:0]         rsp_fetch_bytes,
   output logic                                     rsp_fetch_needed,
   output logic                                     rsp_last_run
);

   localparam int SW      = $clog2(CACHE_ENTRIES);
   localparam int IDX_W   = drc_pkg::IDX_W;
   localparam int CNT_W   = drc_pkg::CNT_W;
   localparam int ADDR_W  = drc_pkg::ADDR_W;
   localparam int BYTES_W = drc_pkg::BYTES_W;
   localparam int TAG_W   = drc_pkg::TAG_W;
   localparam int SLOT_OW = drc_pkg::SLOT_OUT_W;
   localparam int EB_W    = $clog2(ELEMENT_BYTES + 1);
   localparam int PROD_W  = IDX_W + EB_W;
   localparam int LB_W    = CNT_W + EB_W;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_RESULT,
      ST_UPDATE
   } state_type;

   state_type           state_ff;
   logic [ADDR_W-1:0]   base_ff;
   logic [SW-1:0]       clr_ff;
   logic [SW-1:0]       run_slot_ff;
   logic [IDX_W-1:0]    run_idx_ff;
   logic [CNT_W-1:0]    run_len_ff;
   logic                run_last_ff;
   logic [IDX_W-1:0]    idx2_ff;
   logic [CNT_W-1:0]    len2_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic                cmp_vld_ff;
   logic [IDX_W-1:0]    want_ff;
   logic                miss_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic                rsp_valid_ff;
   logic [SLOT_OW-1:0]  rsp_slot_ff;
   logic [IDX_W-1:0]    rsp_run_index_ff;
   logic [ADDR_W-1:0]   rsp_fetch_address_ff;
   logic [BYTES_W-1:0]  rsp_fetch_bytes_ff;
   logic                rsp_fetch_needed_ff;
   logic                rsp_last_run_ff;

   logic                ram_we;
   logic [SW-1:0]       ram_waddr, ram_raddr, cur_slot;
   logic [TAG_W-1:0]    ram_wdata, ram_rdata;
   logic [IDX_W-1:0]    cur_idx;
   logic                tag_hit;
   logic [LB_W-1:0]     len_bytes;
   logic                rsp_load;

   drc_ram #(
      .WIDTH (TAG_W),
      .DEPTH (CACHE_ENTRIES)
   ) u_tags (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Slot and element index of the current step within the run
   assign cur_slot = run_slot_ff + SW'(cnt_ff);
   assign cur_idx  = run_idx_ff + IDX_W'(cnt_ff);

   // Tag RAM access: clearing pass or run update on write, lookup on read
   always_comb begin
      ram_we    = (state_ff == ST_CLEAR) || (state_ff == ST_UPDATE);
      ram_waddr = (state_ff == ST_CLEAR) ? clr_ff : cur_slot;
      ram_wdata = (state_ff == ST_CLEAR) ? '0 : {1'b1, cur_idx};
      ram_raddr = cur_slot;
   end

   assign tag_hit   = ram_rdata[TAG_W-1] && (ram_rdata[IDX_W-1:0] == want_ff);
   assign len_bytes = LB_W'(run_len_ff) * LB_W'(ELEMENT_BYTES);

   assign clearing = (state_ff == ST_CLEAR);
   assign q_ready  = (state_ff == ST_IDLE);

   // Response register takes a run result once it is free or being drained, unless the base is being written
   assign rsp_load = (state_ff == ST_RESULT) && (!rsp_valid_ff || rsp_ready)
                     && !csr_write_enable;

   // Byte offset of the run start, registered ahead of the address add
   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(run_idx_ff) * PROD_W'(ELEMENT_BYTES);
   end

   // Run sequencer with response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         base_ff      <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         // a tag read issued now is compared next cycle
         cmp_vld_ff <= (state_ff == ST_LOOKUP) && (cnt_ff != run_len_ff)
                       && !csr_write_enable;
         if (csr_write_enable) begin
            // new base invalidates every tag
            base_ff  <= csr_write_data;
            clr_ff   <= '0;
            state_ff <= ST_CLEAR;
         end else begin
            case (state_ff)
               ST_CLEAR: begin
                  clr_ff <= clr_ff + 1'b1;
                  if (clr_ff == SW'(CACHE_ENTRIES - 1)) begin
                     state_ff <= ST_IDLE;
                  end
               end
               ST_IDLE: begin
                  if (q_valid) begin
                     run_slot_ff <= q_slot;
                     run_idx_ff  <= q_run.idx1;
                     run_len_ff  <= q_run.len1;
                     run_last_ff <= (q_run.len2 == '0);
                     idx2_ff     <= q_run.idx2;
                     len2_ff     <= q_run.len2;
                     cnt_ff      <= '0;
                     miss_ff     <= 1'b0;
                     state_ff    <= ST_LOOKUP;
                  end
               end
               ST_LOOKUP: begin
                  // one tag read issued and one compared per cycle
                  if (cnt_ff != run_len_ff) begin
                     want_ff <= cur_idx;
                     cnt_ff  <= cnt_ff + 1'b1;
                  end
                  if (cmp_vld_ff && !tag_hit) begin
                     miss_ff <= 1'b1;
                  end
                  if ((cnt_ff == run_len_ff) && !cmp_vld_ff) begin
                     state_ff <= ST_RESULT;
                  end
               end
               ST_RESULT: begin
                  if (rsp_load) begin
                     rsp_slot_ff          <= SLOT_OW'(run_slot_ff);
                     rsp_run_index_ff     <= run_idx_ff;
                     rsp_fetch_address_ff <= base_ff + ADDR_W'(prod_ff);
                     rsp_fetch_bytes_ff   <= BYTES_W'(len_bytes);
                     rsp_fetch_needed_ff  <= miss_ff;
                     rsp_last_run_ff      <= run_last_ff;
                     cnt_ff               <= '0;
                     if (miss_ff) begin
                        state_ff <= ST_UPDATE;
                     end else if (run_last_ff) begin
                        state_ff <= ST_IDLE;
                     end else begin
                        run_slot_ff <= '0;
                        run_idx_ff  <= idx2_ff;
                        run_len_ff  <= len2_ff;
                        run_last_ff <= 1'b1;
                        miss_ff     <= 1'b0;
                        state_ff    <= ST_LOOKUP;
                     end
                  end
               end
               ST_UPDATE: begin
                  // one tag written per cycle
                  if (cnt_ff == run_len_ff - 1'b1) begin
                     cnt_ff <= '0;
                     if (run_last_ff) begin
                        state_ff <= ST_IDLE;
                     end else begin
                        run_slot_ff <= '0;
                        run_idx_ff  <= idx2_ff;
                        run_len_ff  <= len2_ff;
                        run_last_ff <= 1'b1;
                        miss_ff     <= 1'b0;
                        state_ff    <= ST_LOOKUP;
                     end
                  end else begin
                     cnt_ff <= cnt_ff + 1'b1;
                  end
               end
               default: begin
                  state_ff <= ST_IDLE;
               end
            endcase
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_slot          = rsp_slot_ff;
   assign rsp_run_index     = rsp_run_index_ff;
   assign rsp_fetch_address = rsp_fetch_address_ff;
   assign rsp_fetch_bytes   = rsp_fetch_bytes_ff;
   assign rsp_fetch_needed  = rsp_fetch_needed_ff;
   assign rsp_last_run      = rsp_last_run_ff;

endmodule

`default_nettype wire

FILE: rtl/core/direct_mapped_range_cache.sv
// Top level of the direct-mapped range cache tag store.
// Depends on drc_pkg, drc_front, drc_queue and drc_back.
`timescale 1ns / 1ps
`default_nettype none

// A request names a range of elements (first index, count); the block splits it at the
// table end into one or two runs and returns one response per run, telling whether any
// tag of the run missed (fetch needed) plus the fetch address and byte length, and it
// then marks the run's slots as holding those elements. A count of zero gives no
// response. The front end takes each request in turn through accept, a reciprocal
// multiply that gives the quotient by the table size, a multiply-subtract that leaves
// the first slot, and a hand-off into a two-entry queue. The back end looks up each
// run on its single tag RAM read port (one tag compared per cycle), writes the run's
// tags when the run missed, and waits while the response register is held by the
// receiver; the two ends overlap through the queue. After reset and after every
// write of the base address register the tag RAM is cleared one slot per cycle, and
// no request is accepted until the clearing pass is done.
module direct_mapped_range_cache #(
   parameter int CACHE_ENTRIES = 256,
   parameter int ELEMENT_BYTES = 64
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write_enable,
   input  wire logic [drc_pkg::ADDR_W-1:0]        csr_write_data,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [drc_pkg::IDX_W-1:0]         req_first_index,
   input  wire logic [drc_pkg::CNT_W-1:0]         req_element_count,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic      [drc_pkg::SLOT_OUT_W-1:0]    rsp_slot,
   output logic      [drc_pkg::IDX_W-1:0]         rsp_run_index,
   output logic      [drc_pkg::ADDR_W-1:0]        rsp_fetch_address,
   output logic      [drc_pkg::BYTES_W-1:0]       rsp_fetch_bytes,
   output logic                                   rsp_fetch_needed,
   output logic                                   rsp_last_run
);

   localparam int SW  = $clog2(CACHE_ENTRIES);
   localparam int QDW = SW + $bits(drc_pkg::run_type);

   logic             clearing;
   logic             fq_valid, fq_ready, qb_valid, qb_ready;
   logic [SW-1:0]    fq_slot, qb_slot;
   drc_pkg::run_type fq_run, qb_run;

   drc_front #(
      .CACHE_ENTRIES (CACHE_ENTRIES)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .clearing          (clearing),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_first_index   (req_first_index),
      .req_element_count (req_element_count),
      .q_valid           (fq_valid),
      .q_ready           (fq_ready),
      .q_slot            (fq_slot),
      .q_run             (fq_run)
   );

   drc_queue #(
      .WIDTH (QDW),
      .DEPTH (drc_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_data   ({fq_slot, fq_run}),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_data  ({qb_slot, qb_run})
   );

   drc_back #(
      .CACHE_ENTRIES (CACHE_ENTRIES),
      .ELEMENT_BYTES (ELEMENT_BYTES)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .clearing          (clearing),
      .q_valid           (qb_valid),
      .q_ready           (qb_ready),
      .q_slot            (qb_slot),
      .q_run             (qb_run),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_slot          (rsp_slot),
      .rsp_run_index     (rsp_run_index),
      .rsp_fetch_address (rsp_fetch_address),
      .rsp_fetch_bytes   (rsp_fetch_bytes),
      .rsp_fetch_needed  (rsp_fetch_needed),
      .rsp_last_run      (rsp_last_run)
   );

   // A base write always starts a clearing pass
   a_csr_clears: assert property (@(posedge clock) disable iff (reset)
      csr_write_enable |=> clearing)
      else $error("base write did not start a tag clearing pass");

   // Leaving reset, the tag RAM is being cleared
   a_reset_clears: assert property (@(posedge clock)
      $fell(reset) |-> clearing)
      else $error("no clearing pass after reset");

   // The response after a non-final run is the wrapped run at slot 0
   a_second_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_run |=>
         !rsp_valid || (rsp_slot == '0 && rsp_last_run))
      else $error("run following a non-final run is not a final run at slot 0");

endmodule

`default_nettype wire
